### rtl/core/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; every macro expands to one concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, ignored while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

### rtl/core/tcfb_pkg.sv
// Shared types and constants for the command frame builder.
// No dependencies; used by every module of the block.
package tcfb_pkg;

   localparam logic [7:0]  HDR_START = 8'hFD;
   localparam logic [7:0]  HDR_CMD   = 8'h01;
   localparam logic [15:0] LEN_EXTRA = 16'd3;

   localparam int unsigned MAX_BYTES = 6;
   localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 1);
   localparam int unsigned PTR_W     = $clog2(MAX_BYTES);

   localparam logic REQ_START   = 1'b0;
   localparam logic REQ_PAYLOAD = 1'b1;

   // Output bytes caused by one input item, first byte in entry 0.
   typedef struct packed {
      logic [MAX_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
      logic                      has_sum;   // last byte is the checksum
   } burst_type;

endpackage

### rtl/core/tcfb_frame_gen.sv
// Input register and frame logic: header, payload pass-through, checksum.
// Depends on tcfb_pkg; feeds at most one burst per item to tcfb_byte_ser.
module tcfb_frame_gen (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,
   input  logic                req_tuser,
   input  logic                csr_valid,
   input  logic [1:0]          csr_data,
   input  logic                burst_ready,
   output logic                burst_valid,
   output tcfb_pkg::burst_type burst
);

   logic        hold_valid_ff, hold_valid_in;
   logic        hold_type_ff;
   logic [15:0] hold_len_ff;
   logic [7:0]  hold_data_ff;

   logic [1:0]  enc_ff;
   logic [7:0]  xor_ff, xor_in;
   logic [15:0] remain_ff, remain_in;
   logic        open_ff, open_in;

   logic        is_start;
   logic        drop;
   logic        advance;
   logic [15:0] field;
   logic [7:0]  hdr_sum;
   logic [7:0]  pay_sum;
   logic [15:0] remain_dec;

   assign is_start   = (hold_type_ff == tcfb_pkg::REQ_START);
   assign drop       = hold_valid_ff && !is_start && !open_ff;
   assign burst_valid = hold_valid_ff && !drop;
   assign advance    = drop || (burst_valid && burst_ready);
   assign req_tready = !hold_valid_ff || advance;

   assign field      = hold_len_ff + tcfb_pkg::LEN_EXTRA;
   assign hdr_sum    = tcfb_pkg::HDR_START ^ field[15:8] ^ field[7:0]
                       ^ tcfb_pkg::HDR_CMD ^ {6'd0, enc_ff};
   assign pay_sum    = xor_ff ^ hold_data_ff;
   assign remain_dec = remain_ff - 16'd1;

   always_comb begin
      burst     = '0;
      xor_in    = xor_ff;
      remain_in = remain_ff;
      open_in   = open_ff;
      if (is_start) begin
         burst.bytes[0] = tcfb_pkg::HDR_START;
         burst.bytes[1] = field[15:8];
         burst.bytes[2] = field[7:0];
         burst.bytes[3] = tcfb_pkg::HDR_CMD;
         burst.bytes[4] = {6'd0, enc_ff};
         burst.bytes[5] = hdr_sum;
         burst.has_sum  = (hold_len_ff == 16'd0);
         burst.count    = burst.has_sum ? tcfb_pkg::CNT_W'(6) : tcfb_pkg::CNT_W'(5);
         xor_in         = hdr_sum;
         remain_in      = hold_len_ff;
         open_in        = !burst.has_sum;
      end else begin
         burst.bytes[0] = hold_data_ff;
         burst.bytes[1] = pay_sum;
         burst.has_sum  = (remain_dec == 16'd0);
         burst.count    = burst.has_sum ? tcfb_pkg::CNT_W'(2) : tcfb_pkg::CNT_W'(1);
         xor_in         = pay_sum;
         remain_in      = remain_dec;
         open_in        = !burst.has_sum;
      end
   end

   assign hold_valid_in = req_tready ? req_tvalid : hold_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         enc_ff        <= 2'd0;
         xor_ff        <= 8'd0;
         remain_ff     <= 16'd0;
         open_ff       <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         if (csr_valid) begin
            enc_ff <= csr_data;
         end
         if (burst_valid && burst_ready) begin
            xor_ff    <= xor_in;
            remain_ff <= remain_in;
            open_ff   <= open_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         hold_type_ff <= req_tuser;
         hold_len_ff  <= req_tdata[15:0];
         hold_data_ff <= req_tdata[23:16];
      end
   end

endmodule

### rtl/core/tcfb_byte_ser.sv
// Result register holding one burst, sent out one byte per beat.
// Depends on tcfb_pkg; takes bursts from tcfb_frame_gen.
module tcfb_byte_ser (
   input  logic                clock,
   input  logic                reset,
   input  logic                burst_valid,
   output logic                burst_ready,
   input  tcfb_pkg::burst_type burst,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   tcfb_pkg::burst_type             burst_ff;
   logic                            valid_ff;
   logic [tcfb_pkg::PTR_W-1:0]      ptr_ff;
   logic                            last;
   logic                            fire;

   assign last        = (tcfb_pkg::CNT_W'(ptr_ff) == (burst_ff.count - tcfb_pkg::CNT_W'(1)));
   assign fire        = valid_ff && rsp_tready;
   assign burst_ready = !valid_ff || (fire && last);

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = burst_ff.bytes[ptr_ff];
   assign rsp_tlast  = burst_ff.has_sum && last;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ptr_ff   <= '0;
      end else if (burst_ready) begin
         valid_ff <= burst_valid;
         ptr_ff   <= '0;
      end else if (fire) begin
         ptr_ff <= ptr_ff + tcfb_pkg::PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (burst_ready && burst_valid) begin
         burst_ff <= burst;
      end
   end

endmodule

### rtl/core/tts_command_frame_builder.sv
// Speech-module command frame builder. A start beat (tuser 0) emits five header
// bytes FD, len+3 (big endian), 01, encoding; payload beats (tuser 1) pass through,
// and after the announced count an XOR checksum beat follows with tlast set. A
// zero-length start ends with its checksum at once; a new start abandons an open
// frame; payload outside a frame is dropped without output. Input beats are taken
// one per cycle into an input register while the output keeps up, and one byte goes
// out per cycle while rsp_tready is high: 5 or 6 per start item, 1 or 2 per payload
// item, so the byte serializer sets the sustained rate. The encoding register is
// written via the csr port, which is always ready, and affects later headers only.
module tts_command_frame_builder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [15:0] frame_length, [23:16] data_byte
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,   // frame_end
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_data     // text_encoding
);

   tcfb_pkg::burst_type burst;
   logic                burst_valid;
   logic                burst_ready;

   assign csr_ready = 1'b1;

   tcfb_frame_gen u_gen (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .csr_valid   (csr_valid),
      .csr_data    (csr_data),
      .burst_ready (burst_ready),
      .burst_valid (burst_valid),
      .burst       (burst)
   );

   tcfb_byte_ser u_ser (
      .clock       (clock),
      .reset       (reset),
      .burst_valid (burst_valid),
      .burst_ready (burst_ready),
      .burst       (burst),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

### rtl/core/tcfb_checker.sv
// Port-level checks for the command frame builder, bound to the top level.
// Depends on assert_macros.svh and tcfb_pkg.
`include "assert_macros.svh"

module tcfb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [7:0]  rsp_tdata,
   input logic        rsp_tlast
);

   // set when the next output beat must open a new frame
   logic frame_gap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_gap_ff <= 1'b1;
      end else if (rsp_tvalid && rsp_tready) begin
         frame_gap_ff <= rsp_tlast;
      end
   end

   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `ASSERT_CLK(a_frame_opens_fd, clock, reset, rsp_tvalid && frame_gap_ff |-> rsp_tdata == tcfb_pkg::HDR_START)
   `ASSERT_CLK(a_stall_only_on_output, clock, reset, !req_tready |-> rsp_tvalid)
   `ASSERT_CLK_ALWAYS(a_reset_clears_out, clock, reset |=> !rsp_tvalid)

endmodule

bind tts_command_frame_builder tcfb_checker u_tcfb_checker (.*);
